// ===== sv/rnev_pkg.sv =====
// ----------------------------------------------------------------------------
// rnev_pkg: shared types and constants for the RGB neighbor edge vote block
// Pixel and register layouts, line store geometry and the vote function.
// ----------------------------------------------------------------------------
package rnev_pkg;

  // Line store geometry.
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 12;
  localparam int unsigned PixW     = 24;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegMinVotes  = 2'd1,
    RegWidth     = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgDataW = 12;

  // Register reset values.
  localparam logic [7:0]        ThresholdRst = 8'd0;
  localparam logic [2:0]        MinVotesRst  = 3'd1;
  localparam logic [WidthW-1:0] WidthRst     = WidthW'(640);

  typedef logic [PixW-1:0] pix_t;
  typedef logic [2:0]      votes_t;

  // Count the channels whose absolute difference exceeds the threshold.
  function automatic logic [1:0] chan_votes(pix_t a, pix_t b, logic [7:0] thr);
    logic [1:0] n;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    n = 2'd0;
    for (int c = 0; c < 3; c++) begin
      x = a[c*8 +: 8];
      y = b[c*8 +: 8];
      d = (x > y) ? (x - y) : (y - x);
      if (d > thr) n = n + 2'd1;
    end
    return n;
  endfunction

endpackage

// ===== sv/rnev_if.sv =====
// ----------------------------------------------------------------------------
// rnev interfaces: pixel, result and configuration channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rnev_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface rnev_res_if;
  logic                  valid;
  logic                  ready;
  logic                  edge_pixel;
  rnev_pkg::votes_t      vote_count;

  modport source (output valid, edge_pixel, vote_count, input ready);
  modport sink   (input valid, edge_pixel, vote_count, output ready);
endinterface

interface rnev_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    index;
  logic [rnev_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rnev_ram.sv =====
// ----------------------------------------------------------------------------
// rnev_ram: generic single-clock RAM
// One write port, one read port with enable and registered, read-first data.
// ----------------------------------------------------------------------------
module rnev_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rgb_neighbor_edge_vote_top.sv =====
// ----------------------------------------------------------------------------
// rgb_neighbor_edge_vote_top: edge marking for a raster RGB pixel stream
// Votes over left and upper channel differences against a threshold.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock unless the output stalls it, and
// returns one result item per pixel through the stage one and output
// registers. Each pixel reads the line store entry of its column and writes
// itself back to that entry in the same cycle; the two-port line store RAM
// with a read-first registered output sets the read stage, and the vote
// sum and compare against min_votes sit in the second stage ahead of the
// output register. Configuration writes are taken at any time but must only
// be issued while no pixel is in flight. Line store entries are not cleared
// at reset; a row above is only read after the first row of a frame has
// written it, so frame_start must open each image.
module rgb_neighbor_edge_vote_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rnev_pix_if.sink   in_i,
  rnev_res_if.source out_o,
  rnev_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [7:0]                    thr_q;
  logic [2:0]                    minv_q;
  logic [rnev_pkg::WidthW-1:0]   width_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= rnev_pkg::ThresholdRst;
      minv_q  <= rnev_pkg::MinVotesRst;
      width_q <= rnev_pkg::WidthRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rnev_pkg::RegThreshold: thr_q   <= cfg_i.data[7:0];
        rnev_pkg::RegMinVotes:  minv_q  <= cfg_i.data[2:0];
        rnev_pkg::RegWidth:     width_q <= cfg_i.data[rnev_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Effective width: zero counts as one, large values saturate.
  logic [rnev_pkg::WidthW-1:0] eff_w;
  always_comb begin
    if (width_q == '0) begin
      eff_w = rnev_pkg::WidthW'(1);
    end else if (width_q > rnev_pkg::WidthW'(rnev_pkg::MaxWidth)) begin
      eff_w = rnev_pkg::WidthW'(rnev_pkg::MaxWidth);
    end else begin
      eff_w = width_q;
    end
  end

  // Handshake control.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic in_acc;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // Raster position registers.
  logic [rnev_pkg::ColW-1:0] col_q;
  logic [rnev_pkg::ColW-1:0] col_d;
  logic                      first_q;
  logic                      first_d;
  logic [rnev_pkg::ColW-1:0] col_cur;
  logic                      first_cur;
  logic [rnev_pkg::WidthW-1:0] col_inc;
  rnev_pkg::pix_t            pix;

  assign pix = {in_i.blue, in_i.green, in_i.red};

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    if (in_i.frame_start) begin
      col_cur   = '0;
      first_cur = 1'b1;
    end else if ({1'b0, col_q} >= eff_w) begin
      col_cur   = '0;
      first_cur = 1'b0;
    end else begin
      col_cur   = col_q;
      first_cur = first_q;
    end
    col_inc = {1'b0, col_cur} + rnev_pkg::WidthW'(1);
    if (col_inc >= eff_w) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d   = col_inc[rnev_pkg::ColW-1:0];
      first_d = first_cur;
    end
  end

  rnev_pkg::pix_t left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
    end else if (in_acc) begin
      col_q   <= col_d;
      first_q <= first_d;
      left_q  <= pix;
    end
  end

  // Line store: read the row above and write the current pixel in place.
  rnev_pkg::pix_t up_pix;

  rnev_ram #(
    .WIDTH(rnev_pkg::PixW),
    .DEPTH(rnev_pkg::MaxWidth)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(col_cur),
    .wdata_i(pix),
    .re_i   (in_acc),
    .raddr_i(col_cur),
    .rdata_o(up_pix)
  );

  // Stage one: pixel and neighbors wait for the line store data.
  rnev_pkg::pix_t s1_pix_q;
  rnev_pkg::pix_t s1_left_q;
  logic           s1_has_left_q;
  logic           s1_has_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= pix;
      s1_left_q     <= left_q;
      s1_has_left_q <= (col_cur != '0);
      s1_has_up_q   <= !first_cur;
    end
  end

  // Vote count over both directions.
  logic [1:0]       left_votes;
  logic [1:0]       up_votes;
  rnev_pkg::votes_t votes;

  always_comb begin
    left_votes = s1_has_left_q ? rnev_pkg::chan_votes(s1_pix_q, s1_left_q, thr_q) : 2'd0;
    up_votes   = s1_has_up_q ? rnev_pkg::chan_votes(s1_pix_q, up_pix, thr_q) : 2'd0;
    votes      = {1'b0, left_votes} + {1'b0, up_votes};
  end

  // Output register.
  logic             edge_q;
  rnev_pkg::votes_t votes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      edge_q  <= (votes >= minv_q);
      votes_q <= votes;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.edge_pixel = edge_q;
  assign out_o.vote_count = votes_q;

  // The column position always stays inside the row after a pixel.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ({1'b0, col_q} < $past(eff_w)))
    else $error("column position left the row");

  // A vote count never exceeds six.
  a_votes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (votes_q <= 3'd6))
    else $error("vote count out of range");

  // A stalled stage one keeps its line store data.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(up_pix)))
    else $error("line store data changed under a stalled item");

  // The first pixel of a frame compares with no neighbor.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.frame_start) |=> (!s1_has_left_q && !s1_has_up_q))
    else $error("frame start pixel compared with a neighbor");

endmodule
